// File: rtl/core/fbfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbfa_pkg;

	// default sizing of the heap and the block table
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEAP_BYTES_DEF   = 1048576;
	localparam int HEADER_BYTES_DEF = 8;

	// fixed field widths
	localparam int REQ_W  = 20;
	localparam int OFF_W  = 20;
	localparam int TOT_W  = 21;
	localparam int STAT_W = 2;

	// request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// fit mode codes
	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_REUSED   = 2'd0;
	localparam logic [STAT_W-1:0] ST_APPENDED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FREED    = 2'd3;

	// controller to walk unit
	typedef struct packed {
		logic clear;
		logic valid;
		logic is_free;
		logic best_fit;
	} walk_ctl_t;

	// walk unit to controller
	typedef struct packed {
		logic found;
		logic stop;
	} walk_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/fbfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fbfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/fbfa_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module fbfa_walk #(
	parameter int MAX_BLOCKS   = fbfa_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES   = fbfa_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = fbfa_pkg::HEADER_BYTES_DEF,
	localparam int IW = $clog2(MAX_BLOCKS),
	localparam int SW = $clog2(HEAP_BYTES + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire fbfa_pkg::walk_ctl_t        ctl,
	input  wire logic [fbfa_pkg::TOT_W-1:0] total,
	input  wire logic [fbfa_pkg::OFF_W-1:0] free_offset,
	input  wire logic [SW-1:0]              entry_size,
	input  wire logic                       entry_free,
	input  wire logic [IW-1:0]              entry_idx,
	output fbfa_pkg::walk_sts_t             sts,
	output logic      [IW-1:0]              best_idx,
	output logic      [SW-1:0]              best_start
);

	localparam int AW = ((SW > fbfa_pkg::TOT_W) ? SW : fbfa_pkg::TOT_W) + 1;

	logic          found_q;
	logic [SW-1:0] start_q;
	logic [IW-1:0] best_idx_q;
	logic [SW-1:0] best_diff_q;
	logic [SW-1:0] best_start_q;

	logic [AW-1:0] size_x;
	logic [AW-1:0] total_x;
	logic [SW-1:0] diff;
	logic          fits;
	logic          better;
	logic          hit_free;
	logic          take;

	assign size_x  = AW'(entry_size);
	assign total_x = AW'(total);
	assign diff    = SW'(size_x - total_x);

	// free block large enough for this allocation
	assign fits   = ctl.valid && !ctl.is_free && entry_free && (size_x >= total_x);
	assign better = !found_q || (diff < best_diff_q);
	// user data of this block starts at the offset being freed
	assign hit_free = ctl.valid && ctl.is_free &&
		((AW'(start_q) + AW'(HEADER_BYTES)) == AW'(free_offset));
	assign take = (fits && better) || hit_free;

	assign sts.stop  = hit_free || (fits && !ctl.best_fit);
	assign sts.found = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			start_q <= '0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
			start_q <= '0;
		end else if (ctl.valid) begin
			start_q <= start_q + entry_size;
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= entry_idx;
			best_diff_q  <= diff;
			best_start_q <= start_q;
		end
	end

	assign best_idx   = best_idx_q;
	assign best_start = best_start_q;

endmodule

`default_nettype wire

// File: rtl/core/first_or_best_fit_block_allocator.sv
// sequence: a start beat is accepted in idle, then the scan state walks the N table entries
// (N = block count, fewer when a first-fit or free search hits early), then the decide state
// updates the table and registers the result; no new request is taken until the block is idle
// the receiver cannot stall: each result is shown for exactly one cycle with done
// reset: arst_n clears block count, heap usage and fit mode; the table itself needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module first_or_best_fit_block_allocator #(
	parameter int MAX_BLOCKS   = fbfa_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES   = fbfa_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = fbfa_pkg::HEADER_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request beat
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        opcode,
	input  wire logic [fbfa_pkg::REQ_W-1:0]  request_size,
	input  wire logic [fbfa_pkg::OFF_W-1:0]  free_offset,
	// result beat
	output logic                             done,
	output logic      [fbfa_pkg::OFF_W-1:0]  data_offset,
	output logic      [fbfa_pkg::STAT_W-1:0] status,
	// fit mode register
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = $clog2(HEAP_BYTES + 1);
	localparam int AW = ((SW > fbfa_pkg::TOT_W) ? SW : fbfa_pkg::TOT_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	state_t state_q;

	// request context
	logic                       fit_mode_q;
	logic                       opcode_q;
	logic [fbfa_pkg::TOT_W-1:0] total_q;
	logic [fbfa_pkg::OFF_W-1:0] offset_q;

	// heap bookkeeping
	logic [CW-1:0] count_q;
	logic [SW-1:0] used_q;

	// walk pipeline: read issue counter, then the entry in the read stage
	logic [CW-1:0] iss_q;
	logic          val_s1;
	logic [IW-1:0] idx_s1;

	// result registers
	logic                        done_q;
	logic [fbfa_pkg::OFF_W-1:0]  data_offset_q;
	logic [fbfa_pkg::STAT_W-1:0] status_q;

	logic                  accept;
	logic                  issue;
	logic                  scan_end;
	logic                  is_alloc;
	logic                  app_ok;
	logic [AW-1:0]         used_after;
	logic [AW-1:0]         reuse_off;
	logic [AW-1:0]         app_off;

	fbfa_pkg::walk_ctl_t   ctl;
	fbfa_pkg::walk_sts_t   sts;
	logic [IW-1:0]         best_idx;
	logic [SW-1:0]         best_start;

	// table memories
	logic                  size_we;
	logic                  free_we;
	logic [IW-1:0]         free_waddr;
	logic                  free_wdata;
	logic [SW-1:0]         size_rdata;
	logic                  free_rdata;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign is_alloc  = (opcode_q == fbfa_pkg::OP_ALLOC);

	// one table read per cycle until every block is issued or the walk hits
	assign issue    = (state_q == S_SCAN) && (iss_q != count_q) && !sts.stop;
	// the walk ends on a hit or once the last issued entry is in the read stage
	assign scan_end = (state_q == S_SCAN) && (sts.stop || (iss_q == count_q));

	assign ctl.clear    = accept;
	assign ctl.valid    = val_s1 && (state_q == S_SCAN);
	assign ctl.is_free  = !is_alloc;
	assign ctl.best_fit = (fit_mode_q == fbfa_pkg::FIT_BEST);

	// append needs a free slot and room at the heap end
	assign used_after = AW'(used_q) + AW'(total_q);
	assign app_ok     = (count_q < CW'(MAX_BLOCKS)) && (used_after <= AW'(HEAP_BYTES));
	assign reuse_off  = AW'(best_start) + AW'(HEADER_BYTES);
	assign app_off    = AW'(used_q) + AW'(HEADER_BYTES);

	// writes happen only in the decide cycle, after the walk has drained
	assign size_we    = (state_q == S_DECIDE) && is_alloc && !sts.found && app_ok;
	assign free_we    = (state_q == S_DECIDE) && (sts.found || (is_alloc && app_ok));
	assign free_waddr = sts.found ? best_idx : count_q[IW-1:0];
	assign free_wdata = !is_alloc;

	fbfa_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_BLOCKS)
	) u_size_ram (
		.clk  (clk),
		.we   (size_we),
		.waddr(count_q[IW-1:0]),
		.wdata(SW'(total_q)),
		.re   (issue),
		.raddr(iss_q[IW-1:0]),
		.rdata(size_rdata)
	);

	fbfa_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCKS)
	) u_free_ram (
		.clk  (clk),
		.we   (free_we),
		.waddr(free_waddr),
		.wdata(free_wdata),
		.re   (issue),
		.raddr(iss_q[IW-1:0]),
		.rdata(free_rdata)
	);

	fbfa_walk #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.total      (total_q),
		.free_offset(offset_q),
		.entry_size (size_rdata),
		.entry_free (free_rdata),
		.entry_idx  (idx_s1),
		.sts        (sts),
		.best_idx   (best_idx),
		.best_start (best_start)
	);

	// request context, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= opcode;
			total_q  <= fbfa_pkg::TOT_W'(request_size) + fbfa_pkg::TOT_W'(HEADER_BYTES);
			offset_q <= free_offset;
		end
		if (issue) begin
			idx_s1 <= iss_q[IW-1:0];
		end
	end

	// controller state, bookkeeping and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fit_mode_q    <= fbfa_pkg::FIT_FIRST;
			count_q       <= '0;
			used_q        <= '0;
			iss_q         <= '0;
			val_s1        <= 1'b0;
			done_q        <= 1'b0;
			data_offset_q <= '0;
			status_q      <= fbfa_pkg::ST_REUSED;
		end else begin
			done_q <= 1'b0;
			val_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				fit_mode_q <= cfg_data;
			end
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						iss_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (!is_alloc) begin
						data_offset_q <= '0;
						status_q      <= fbfa_pkg::ST_FREED;
					end else if (sts.found) begin
						data_offset_q <= reuse_off[fbfa_pkg::OFF_W-1:0];
						status_q      <= fbfa_pkg::ST_REUSED;
					end else if (app_ok) begin
						data_offset_q <= app_off[fbfa_pkg::OFF_W-1:0];
						status_q      <= fbfa_pkg::ST_APPENDED;
						count_q       <= count_q + 1'b1;
						used_q        <= SW'(used_after);
					end else begin
						data_offset_q <= '0;
						status_q      <= fbfa_pkg::ST_NO_SPACE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign data_offset = data_offset_q;
	assign status      = status_q;

endmodule

`default_nettype wire

// File: rtl/core/fbfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fbfa_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [fbfa_pkg::OFF_W-1:0]  data_offset,
	input wire logic [fbfa_pkg::STAT_W-1:0] status
);

	// an accepted request raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request in progress");

	// one beat per request, never two in a row
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// no offset on failed allocations and on frees
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == fbfa_pkg::ST_NO_SPACE || status == fbfa_pkg::ST_FREED))
		|-> (data_offset == '0))
		else $error("nonzero offset on free or out of space result");

endmodule

bind first_or_best_fit_block_allocator fbfa_checker u_fbfa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.data_offset(data_offset),
	.status     (status)
);

`default_nettype wire

// File: tb/fbfa_heap_monitor.sv
`timescale 1ns / 1ps

module fbfa_heap_monitor
	import fbfa_pkg::*;
#(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              opcode,
	input  wire logic [REQ_W-1:0]  request_size,
	input  wire logic [OFF_W-1:0]  free_offset,
	input  wire logic              done,
	input  wire logic [OFF_W-1:0]  data_offset,
	input  wire logic [STAT_W-1:0] status,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic              cfg_data,
	output int unsigned            mismatch_count,
	output int unsigned            results_due
);

	typedef struct packed {
		logic [OFF_W-1:0]  offset;
		logic [STAT_W-1:0] stat;
	} heap_result_t;

	logic [TOT_W-1:0] blk_total [MAX_BLOCKS];
	logic             blk_free  [MAX_BLOCKS];
	int unsigned      blk_count;
	longint unsigned  heap_used;
	logic             fit_sel;
	heap_result_t     result_q [$];

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// walks the block table the way the allocator does and updates the shadow heap
	function automatic heap_result_t apply_request(input logic op,
		input logic [REQ_W-1:0] req, input logic [OFF_W-1:0] off);
		longint unsigned base;
		longint unsigned need;
		longint unsigned slack;
		longint unsigned pick_slack;
		longint unsigned pick_base;
		int              pick;
		bit              hit;
		heap_result_t    r;
		base = 0;
		pick_slack = 0;
		pick_base = 0;
		pick = 0;
		hit = 1'b0;
		r.offset = '0;
		if (op == OP_FREE) begin
			for (int i = 0; i < blk_count; i++) begin
				if (base + HEADER_BYTES == off) begin
					blk_free[i] = 1'b1;
					break;
				end
				base += blk_total[i];
			end
			r.stat = ST_FREED;
			return r;
		end
		need = req + HEADER_BYTES;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_total[i] >= need) begin
				slack = blk_total[i] - need;
				// strict compare keeps the earliest block on a tie
				if (!hit || slack < pick_slack) begin
					hit = 1'b1;
					pick = i;
					pick_slack = slack;
					pick_base = base;
					if (fit_sel == FIT_FIRST)
						break;
				end
			end
			base += blk_total[i];
		end
		if (hit) begin
			blk_free[pick] = 1'b0;
			r.offset = OFF_W'(pick_base + HEADER_BYTES);
			r.stat = ST_REUSED;
		end else if (blk_count >= MAX_BLOCKS || heap_used + need > HEAP_BYTES) begin
			r.stat = ST_NO_SPACE;
		end else begin
			blk_total[blk_count] = TOT_W'(need);
			blk_free[blk_count] = 1'b0;
			r.offset = OFF_W'(heap_used + HEADER_BYTES);
			r.stat = ST_APPENDED;
			blk_count++;
			heap_used += need;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			blk_count = 0;
			heap_used = 0;
			fit_sel = FIT_FIRST;
			result_q.delete();
			results_due <= 0;
		end else begin
			if (done) begin
				if (result_q.size() == 0) begin
					report_mismatch("result beat with no request outstanding");
				end else begin
					want = result_q.pop_front();
					if (data_offset !== want.offset)
						report_mismatch($sformatf("data_offset %0d, expected %0d",
							data_offset, want.offset));
					if (status !== want.stat)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.stat));
				end
			end
			if (cfg_valid && cfg_ready)
				fit_sel = cfg_data;
			if (start && !busy)
				result_q.push_back(apply_request(opcode, request_size, free_offset));
			results_due <= result_q.size();
		end
	end

	final begin
		if (result_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", result_q.size()));
	end

endmodule

// File: tb/tb_first_or_best_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_first_or_best_fit_block_allocator;
	import fbfa_pkg::*;

	localparam int MAX_BLK    = MAX_BLOCKS_DEF;
	// watchdog limit, covers the longest table walk plus a sender gap
	localparam int IDLE_LIMIT = 2000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic              busy;
	logic              opcode       = OP_ALLOC;
	logic [REQ_W-1:0]  request_size = '0;
	logic [OFF_W-1:0]  free_offset  = '0;
	logic              done;
	logic [OFF_W-1:0]  data_offset;
	logic [STAT_W-1:0] status;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic              cfg_data     = FIT_FIRST;

	int unsigned mismatch_count;
	int unsigned results_due;

	// sender burst bookkeeping
	int unsigned burst_left  = 0;
	int unsigned quiet_cycles = 0;

	// offsets handed out by the block, used to build free requests
	logic [OFF_W-1:0] live_offsets     [$];
	logic [OFF_W-1:0] released_offsets [$];
	int unsigned      appended_blocks = 0;

	always #6 clk = ~clk;

	first_or_best_fit_block_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.request_size (request_size),
		.free_offset  (free_offset),
		.done         (done),
		.data_offset  (data_offset),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	fbfa_heap_monitor heap_mon (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.request_size   (request_size),
		.free_offset    (free_offset),
		.done           (done),
		.data_offset    (data_offset),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	// results are picked up mid cycle so the stimulus thread sees them race free
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (status == ST_APPENDED || status == ST_REUSED)
				live_offsets.push_back(data_offset);
			if (status == ST_APPENDED)
				appended_blocks++;
		end
	end

	// watchdog: too many cycles without any beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one request beat; bursts of back-to-back beats separated by random gaps
	task automatic send_request(input logic op, input logic [REQ_W-1:0] sz,
		input logic [OFF_W-1:0] off);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 15);
		end
		burst_left--;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		request_size <= sz;
		free_offset <= off;
		do @(posedge clk); while (busy);
	endtask

	// drain: nothing pending and the block not busy
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (results_due != 0 || busy);
	endtask

	task automatic write_fit_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned      roll;
		int unsigned      pick;
		logic [REQ_W-1:0] sz;
		logic [OFF_W-1:0] off;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_fit_mode(FIT_FIRST);

		// directed, first fit
		// block layout built here: user offsets 8, 16, 124, 172, 380
		send_request(OP_ALLOC, 20'd0, 20'hFFFFF);       // header-only block
		send_request(OP_ALLOC, 20'd100, 20'd0);
		send_request(OP_ALLOC, 20'd40, 20'd0);
		send_request(OP_ALLOC, 20'd200, 20'd0);
		send_request(OP_ALLOC, 20'd40, 20'd0);
		send_request(OP_ALLOC, 20'd1048568, 20'd0);     // whole heap, no room left
		send_request(OP_ALLOC, 20'hFFFFF, 20'd0);       // larger than the heap
		send_request(OP_FREE, 20'hFFFFF, 20'd16);
		send_request(OP_FREE, 20'd0, 20'd16);           // double free
		send_request(OP_FREE, 20'd0, 20'd0);            // unknown offsets
		send_request(OP_FREE, 20'd0, 20'hFFFFF);
		send_request(OP_FREE, 20'd0, 20'd17);
		send_request(OP_FREE, 20'd0, 20'd172);
		send_request(OP_ALLOC, 20'd30, 20'd0);          // first fit takes offset 16
		send_request(OP_FREE, 20'd0, 20'd380);

		// directed, best fit
		wait_idle();
		write_fit_mode(FIT_BEST);
		send_request(OP_ALLOC, 20'd30, 20'd0);          // smaller block at 380 wins
		send_request(OP_ALLOC, 20'd30, 20'd0);          // then the one at 172
		send_request(OP_FREE, 20'd0, 20'd124);
		send_request(OP_FREE, 20'd0, 20'd380);
		send_request(OP_ALLOC, 20'd40, 20'd0);          // tie, earliest block
		send_request(OP_ALLOC, 20'd200, 20'd0);         // nothing fits, append

		// random phases, fit mode flips between them
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_fit_mode((ph % 2 == 0) ? FIT_BEST : FIT_FIRST);
			for (int n = 0; n < 280; n++) begin
				roll = $urandom_range(0, 99);
				sz = REQ_W'($urandom);
				off = OFF_W'($urandom);
				if (roll < 50) begin
					// full-width sizes only once the table is full, so the heap
					// is not eaten before all block slots are in use
					if (appended_blocks < MAX_BLK || $urandom_range(0, 7) != 0)
						sz = ($urandom_range(0, 3) == 0) ? REQ_W'($urandom_range(0, 64))
							: REQ_W'($urandom_range(0, 1500));
					send_request(OP_ALLOC, sz, off);
				end else begin
					if (roll < 80 && live_offsets.size() > 0) begin
						pick = $urandom_range(0, live_offsets.size() - 1);
						off = live_offsets[pick];
						live_offsets.delete(pick);
						released_offsets.push_back(off);
						if (released_offsets.size() > 32)
							void'(released_offsets.pop_front());
					end else if (roll < 88 && released_offsets.size() > 0) begin
						off = released_offsets[$urandom_range(0, released_offsets.size() - 1)];
					end else if (roll < 94 && live_offsets.size() > 0) begin
						// near miss, inside a live block
						off = live_offsets[$urandom_range(0, live_offsets.size() - 1)]
							+ OFF_W'($urandom_range(1, 7));
					end
					send_request(OP_FREE, sz, off);
				end
			end
		end

		wait_idle();
		repeat (MAX_BLK + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: first_or_best_fit_block_allocator.f
rtl/core/fbfa_pkg.sv
rtl/core/fbfa_ram.sv
rtl/core/fbfa_walk.sv
rtl/core/first_or_best_fit_block_allocator.sv
rtl/core/fbfa_checker.sv
tb/fbfa_heap_monitor.sv
tb/tb_first_or_best_fit_block_allocator.sv
